// File: rtl/rbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbs_pkg: shared types and constants of the ray / box slab test
// Field widths, queue sizing and the words passed between front, queue and
// back.
// ---------------------------------------------------------------------------
package rbs_pkg;

   localparam int COORD_W    = 32;               // signed fixed point coordinate
   localparam int FRAC_W     = 16;               // fraction bits
   localparam int HALF_W     = COORD_W - 1;      // unsigned half size
   localparam int DIFF_W     = COORD_W + 2;      // bound minus origin, exact
   localparam int SPLIT_W    = COORD_W - FRAC_W; // numerator bits fed to divider
   localparam int T_W        = COORD_W + 1;      // slab distance plus unbounded marks
   localparam int DIV_STAGES = COORD_W;          // one quotient bit per stage
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic signed [COORD_W-1:0] box_center_x;
      logic signed [COORD_W-1:0] box_center_y;
      logic signed [COORD_W-1:0] box_center_z;
      logic [HALF_W-1:0]         box_half_x;
      logic [HALF_W-1:0]         box_half_y;
      logic [HALF_W-1:0]         box_half_z;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] entry_distance;
   } rsp_type;

   // Per axis classification that travels beside the divider
   typedef struct packed {
      logic par;     // direction is zero
      logic par_in;  // origin lies between the bounds
      logic neg_n;   // near quotient is negative
      logic neg_f;
      logic sat_n;   // near quotient magnitude overflows
      logic sat_f;
   } axis_flag_type;

   typedef struct packed {
      axis_flag_type        flag;
      logic [DIFF_W-1:0]    num_n;
      logic [DIFF_W-1:0]    num_f;
      logic [COORD_W-1:0]   den;
   } axis_job_type;

   typedef struct packed {
      axis_job_type [2:0] axis;
   } job_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [QCNT_W-1:0] level;
   } q_stat_type;

endpackage
`default_nettype wire

// File: rtl/rbs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbs_front: accept and classify
// Forms the slab differences, then signs, magnitudes, parallel and overflow
// flags, and pushes one job word per ray into the queue.
// ---------------------------------------------------------------------------
module rbs_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire rbs_pkg::req_type   req_data,
   input  wire rbs_pkg::q_stat_type q_stat,
   output logic                    push,
   output rbs_pkg::job_type        push_data
);

   logic signed [rbs_pkg::COORD_W-1:0] org [3];
   logic signed [rbs_pkg::COORD_W-1:0] dir [3];
   logic signed [rbs_pkg::COORD_W-1:0] ctr [3];
   logic [rbs_pkg::HALF_W-1:0]         hlf [3];

   logic                               accept;
   logic                               s1_valid_ff;
   logic signed [rbs_pkg::DIFF_W-1:0]  d_lo_in  [3];
   logic signed [rbs_pkg::DIFF_W-1:0]  d_hi_in  [3];
   logic signed [rbs_pkg::DIFF_W-1:0]  d_lo_ff  [3];
   logic signed [rbs_pkg::DIFF_W-1:0]  d_hi_ff  [3];
   logic signed [rbs_pkg::COORD_W-1:0] dir_ff   [3];

   assign org[0] = req_data.origin_x;
   assign org[1] = req_data.origin_y;
   assign org[2] = req_data.origin_z;
   assign dir[0] = req_data.dir_x;
   assign dir[1] = req_data.dir_y;
   assign dir[2] = req_data.dir_z;
   assign ctr[0] = req_data.box_center_x;
   assign ctr[1] = req_data.box_center_y;
   assign ctr[2] = req_data.box_center_z;
   assign hlf[0] = req_data.box_half_x;
   assign hlf[1] = req_data.box_half_y;
   assign hlf[2] = req_data.box_half_z;

   // Hold off when the queue could not take this word and the one in flight
   assign busy   = q_stat.level >= rbs_pkg::QCNT_W'(rbs_pkg::QDEPTH - 1);
   assign accept = start && !busy;

   // Form bound minus origin for both box faces
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d_lo_in[a] = rbs_pkg::DIFF_W'(ctr[a]) - rbs_pkg::DIFF_W'({1'b0, hlf[a]})
                      - rbs_pkg::DIFF_W'(org[a]);
         d_hi_in[a] = rbs_pkg::DIFF_W'(ctr[a]) + rbs_pkg::DIFF_W'({1'b0, hlf[a]})
                      - rbs_pkg::DIFF_W'(org[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int a = 0; a < 3; a++) begin
            d_lo_ff[a] <= d_lo_in[a];
            d_hi_ff[a] <= d_hi_in[a];
            dir_ff[a]  <= dir[a];
         end
      end
   end

   // Classify each axis: pick near and far face, take magnitudes, flag overflow
   always_comb begin
      logic signed [rbs_pkg::DIFF_W-1:0] near_d;
      logic signed [rbs_pkg::DIFF_W-1:0] far_d;
      logic                              dneg;
      logic [rbs_pkg::DIFF_W-1:0]        nn;
      logic [rbs_pkg::DIFF_W-1:0]        nf;
      logic [rbs_pkg::COORD_W-1:0]       dd;
      push_data = '0;
      for (int a = 0; a < 3; a++) begin
         dneg   = dir_ff[a][rbs_pkg::COORD_W-1];
         near_d = dneg ? d_hi_ff[a] : d_lo_ff[a];
         far_d  = dneg ? d_lo_ff[a] : d_hi_ff[a];
         nn     = near_d[rbs_pkg::DIFF_W-1] ? rbs_pkg::DIFF_W'(-near_d)
                                            : rbs_pkg::DIFF_W'(near_d);
         nf     = far_d[rbs_pkg::DIFF_W-1] ? rbs_pkg::DIFF_W'(-far_d)
                                           : rbs_pkg::DIFF_W'(far_d);
         dd     = dneg ? rbs_pkg::COORD_W'(-dir_ff[a]) : rbs_pkg::COORD_W'(dir_ff[a]);
         push_data.axis[a].flag.par    = (dir_ff[a] == '0);
         push_data.axis[a].flag.par_in = (d_lo_ff[a] <= 0) && (d_hi_ff[a] >= 0);
         push_data.axis[a].flag.neg_n  = near_d[rbs_pkg::DIFF_W-1] ^ dneg;
         push_data.axis[a].flag.neg_f  = far_d[rbs_pkg::DIFF_W-1] ^ dneg;
         push_data.axis[a].flag.sat_n  = (nn >> rbs_pkg::SPLIT_W) >= rbs_pkg::DIFF_W'(dd);
         push_data.axis[a].flag.sat_f  = (nf >> rbs_pkg::SPLIT_W) >= rbs_pkg::DIFF_W'(dd);
         push_data.axis[a].num_n       = nn;
         push_data.axis[a].num_f       = nf;
         push_data.axis[a].den         = dd;
      end
   end

   assign push = s1_valid_ff;

endmodule
`default_nettype wire

// File: rtl/rbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbs_queue: job queue between front and back
// Small circular buffer of classified job words.
// ---------------------------------------------------------------------------
module rbs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire rbs_pkg::job_type    push_data,
   input  wire logic                pop,
   output rbs_pkg::job_type         pop_data,
   output rbs_pkg::q_stat_type      stat
);

   rbs_pkg::job_type                mem_ff [rbs_pkg::QDEPTH];
   logic [rbs_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [rbs_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [rbs_pkg::QCNT_W-1:0]      cnt_ff;
   logic [rbs_pkg::QCNT_W-1:0]      cnt_in;

   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == rbs_pkg::QCNT_W'(rbs_pkg::QDEPTH));
   assign stat.level = cnt_ff;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // Track fill level
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && stat.full && !pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && stat.empty))
      else $error("queue read while empty");
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= rbs_pkg::QCNT_W'(rbs_pkg::QDEPTH))
      else $error("queue level out of range");

endmodule
`default_nettype wire

// File: rtl/rbs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbs_div: pipelined restoring divider
// Quotient of (num << FRAC_W) / den, one quotient bit per stage. The caller
// guarantees the quotient fits COORD_W bits or flags the case itself.
// ---------------------------------------------------------------------------
module rbs_div (
   input  wire logic                        clock,
   input  wire logic [rbs_pkg::DIFF_W-1:0]  num,
   input  wire logic [rbs_pkg::COORD_W-1:0] den,
   output logic [rbs_pkg::COORD_W-1:0]      quot
);

   logic [rbs_pkg::COORD_W-1:0] rem_ff  [rbs_pkg::DIV_STAGES];
   logic [rbs_pkg::COORD_W-1:0] den_ff  [rbs_pkg::DIV_STAGES];
   logic [rbs_pkg::SPLIT_W-1:0] bits_ff [rbs_pkg::DIV_STAGES];
   logic [rbs_pkg::COORD_W-1:0] quot_ff [rbs_pkg::DIV_STAGES+1];
   logic [rbs_pkg::COORD_W-1:0] rem_in  [rbs_pkg::DIV_STAGES];
   logic [rbs_pkg::SPLIT_W-1:0] bits_in [rbs_pkg::DIV_STAGES];
   logic [rbs_pkg::COORD_W-1:0] quot_in [rbs_pkg::DIV_STAGES];

   // One trial subtract per stage
   always_comb begin
      logic [rbs_pkg::COORD_W:0] trial;
      logic                      ge;
      for (int s = 0; s < rbs_pkg::DIV_STAGES; s++) begin
         trial      = {rem_ff[s], bits_ff[s][rbs_pkg::SPLIT_W-1]};
         ge         = trial >= {1'b0, den_ff[s]};
         rem_in[s]  = ge ? rbs_pkg::COORD_W'(trial - {1'b0, den_ff[s]})
                         : rbs_pkg::COORD_W'(trial);
         bits_in[s] = bits_ff[s] << 1;
         quot_in[s] = {quot_ff[s][rbs_pkg::COORD_W-2:0], ge};
      end
   end

   // Advance the pipeline
   always_ff @(posedge clock) begin
      rem_ff[0]  <= rbs_pkg::COORD_W'(num >> rbs_pkg::SPLIT_W);
      bits_ff[0] <= num[rbs_pkg::SPLIT_W-1:0];
      den_ff[0]  <= den;
      quot_ff[0] <= '0;
      for (int s = 0; s < rbs_pkg::DIV_STAGES - 1; s++) begin
         rem_ff[s+1]  <= rem_in[s];
         bits_ff[s+1] <= bits_in[s];
         den_ff[s+1]  <= den_ff[s];
      end
      for (int s = 0; s < rbs_pkg::DIV_STAGES; s++) begin
         quot_ff[s+1] <= quot_in[s];
      end
   end

   assign quot = quot_ff[rbs_pkg::DIV_STAGES];

endmodule
`default_nettype wire

// File: rtl/rbs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rbs_back: slab distances and interval intersection
// Drains one job word per cycle, while the queue holds one, through six
// dividers, saturates the distances and intersects the x, y and z intervals.
// ---------------------------------------------------------------------------
module rbs_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rbs_pkg::q_stat_type  q_stat,
   output logic                      pop,
   input  wire rbs_pkg::job_type     pop_data,
   output logic                      rsp_strobe,
   output rbs_pkg::rsp_type          rsp_data
);

   localparam int W  = rbs_pkg::COORD_W;
   localparam int TW = rbs_pkg::T_W;
   localparam int LN = rbs_pkg::DIV_STAGES + 1;
   localparam logic signed [TW-1:0] T_MAX = $signed((TW'(1) << (W - 1)) - TW'(1));
   localparam logic signed [TW-1:0] T_MIN = -T_MAX - TW'(1);
   localparam logic signed [TW-1:0] T_NEG_UNB = T_MIN - TW'(1);
   localparam logic signed [TW-1:0] T_POS_UNB = T_MAX + TW'(1);

   logic [W-1:0]              q_n [3];
   logic [W-1:0]              q_f [3];
   logic                      vld_ff  [LN];
   rbs_pkg::axis_flag_type    flag_ff [LN][3];

   logic                      t_vld_ff;
   logic                      t_ok_ff [3];
   logic signed [TW-1:0]      tn_ff [3];
   logic signed [TW-1:0]      tf_ff [3];

   logic                      m_vld_ff;
   logic                      m_ok_ff;
   logic signed [TW-1:0]      m_tmin_ff;
   logic signed [TW-1:0]      m_tmax_ff;
   logic signed [TW-1:0]      m_tnz_ff;
   logic signed [TW-1:0]      m_tfz_ff;
   logic                      m_okz_ff;

   logic                      m_ok_in;
   logic signed [TW-1:0]      m_tmin_in;
   logic signed [TW-1:0]      m_tmax_in;
   logic                      o_ok;
   logic signed [TW-1:0]      o_tmin;
   rbs_pkg::rsp_type          rsp_in;
   logic                      rsp_strobe_ff;
   rbs_pkg::rsp_type          rsp_data_ff;

   function automatic logic signed [TW-1:0] slab_t(input logic [W-1:0] q,
                                                   input logic neg, input logic sat);
      logic big;
      big = sat || q[W-1];
      if (neg) begin
         slab_t = big ? T_MIN : -$signed({1'b0, q});
      end else begin
         slab_t = big ? T_MAX : $signed({1'b0, q});
      end
   endfunction

   // Pop the queue whenever it is not empty
   assign pop = !q_stat.empty;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbs_div u_div_n (
         .clock (clock),
         .num   (pop_data.axis[a].num_n),
         .den   (pop_data.axis[a].den),
         .quot  (q_n[a])
      );
      rbs_div u_div_f (
         .clock (clock),
         .num   (pop_data.axis[a].num_f),
         .den   (pop_data.axis[a].den),
         .quot  (q_f[a])
      );
   end

   // Carry valid and axis flags beside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LN; s++) begin
            vld_ff[s] <= 1'b0;
         end
         t_vld_ff      <= 1'b0;
         m_vld_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff[0] <= pop;
         for (int s = 0; s < LN - 1; s++) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         t_vld_ff      <= vld_ff[LN-1];
         m_vld_ff      <= t_vld_ff;
         rsp_strobe_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         flag_ff[0][a] <= pop_data.axis[a].flag;
         for (int s = 0; s < LN - 1; s++) begin
            flag_ff[s+1][a] <= flag_ff[s][a];
         end
      end
   end

   // Saturate quotients into slab distances; parallel axes get the unbounded marks
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (flag_ff[LN-1][a].par) begin
            t_ok_ff[a] <= flag_ff[LN-1][a].par_in;
            tn_ff[a]   <= T_NEG_UNB;
            tf_ff[a]   <= T_POS_UNB;
         end else begin
            t_ok_ff[a] <= 1'b1;
            tn_ff[a]   <= slab_t(q_n[a], flag_ff[LN-1][a].neg_n, flag_ff[LN-1][a].sat_n);
            tf_ff[a]   <= slab_t(q_f[a], flag_ff[LN-1][a].neg_f, flag_ff[LN-1][a].sat_f);
         end
      end
   end

   // Intersect x with y
   always_comb begin
      m_ok_in   = t_ok_ff[0] && t_ok_ff[1] && !(tn_ff[0] > tf_ff[1])
                  && !(tn_ff[1] > tf_ff[0]);
      m_tmin_in = (tn_ff[1] > tn_ff[0]) ? tn_ff[1] : tn_ff[0];
      m_tmax_in = (tf_ff[1] < tf_ff[0]) ? tf_ff[1] : tf_ff[0];
   end

   always_ff @(posedge clock) begin
      m_ok_ff   <= m_ok_in;
      m_tmin_ff <= m_tmin_in;
      m_tmax_ff <= m_tmax_in;
      m_tnz_ff  <= tn_ff[2];
      m_tfz_ff  <= tf_ff[2];
      m_okz_ff  <= t_ok_ff[2];
   end

   // Intersect with z and form the result word
   always_comb begin
      o_ok   = m_ok_ff && m_okz_ff && !(m_tmin_ff > m_tfz_ff) && !(m_tnz_ff > m_tmax_ff);
      o_tmin = (m_tnz_ff > m_tmin_ff) ? m_tnz_ff : m_tmin_ff;
      if (o_tmin < T_MIN) begin
         o_tmin = T_MIN;
      end else if (o_tmin > T_MAX) begin
         o_tmin = T_MAX;
      end
      rsp_in.hit            = o_ok;
      rsp_in.entry_distance = o_ok ? W'(o_tmin) : W'(T_MAX);
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_miss_far: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.hit |-> rsp_data.entry_distance == W'(T_MAX))
      else $error("miss word without largest distance");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(m_vld_ff))
      else $error("result word without a job behind it");

endmodule
`default_nettype wire

// File: rtl/ray_box_slab_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ray_box_slab_test: ray versus axis-aligned box slab test
// Front classifies each ray, a short queue decouples it from the divider
// and intersection back end.
// ---------------------------------------------------------------------------
// One ray is taken on every clock edge where start is high and busy is low,
// one result word per ray comes out of the queue and back end pipeline, in
// order, with rsp_strobe high for one cycle; the receiver cannot stall,
// so the back end drains the queue every cycle and busy stays low under
// continuous input. The latency is set mostly by the 32 stage restoring
// divider pipeline (one quotient bit per stage, six dividers side by side).
module ray_box_slab_test (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rbs_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output rbs_pkg::rsp_type      rsp_data
);

   rbs_pkg::q_stat_type q_stat;
   rbs_pkg::job_type    push_data;
   rbs_pkg::job_type    pop_data;
   logic                push;
   logic                pop;

   rbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   rbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   rbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop        (pop),
      .pop_data   (pop_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: ray / box slab test checker
// Drives rays into ray_box_slab_test, directed table first, then random
// rays biased toward hits, and compares every result word against a known
// table row's word, else an in-bench slab intersection predictor.
// ---------------------------------------------------------------------------
module testbench;

   localparam int     N_RANDOM  = 1950;
   localparam int     LATENCY   = 37;
   localparam int     WD_LIMIT  = 2000;
   localparam longint SMAX      = 64'sd2147483647;
   localparam longint SMIN      = -64'sd2147483648;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   rbs_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   rbs_pkg::rsp_type rsp_data;

   rbs_pkg::rsp_type hit_queue[$];
   int      fail_count = 0;
   int      idle_cycles = 0;

   typedef struct {
      rbs_pkg::req_type ray;
      logic             known;
      rbs_pkg::rsp_type want;
   } row_type;

   ray_box_slab_test u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // (diff << FRAC_W) / dir, truncated toward zero, saturated to 32 bits
   function automatic longint slab_quotient(longint diff, longint dir);
      logic          neg;
      logic [127:0]  n, d, q;
      neg = (diff < 0) != (dir < 0);
      n = (diff < 0) ? -diff : diff;
      d = (dir < 0) ? -dir : dir;
      n = n << rbs_pkg::FRAC_W;
      q = n / d;
      if (neg) begin
         if (q > 128'd2147483648) return SMIN;
         return -longint'(q);
      end
      if (q > 128'd2147483647) return SMAX;
      return longint'(q);
   endfunction

   // Slab interval of one axis; returns 0 when this axis alone misses
   function automatic logic axis_span(logic signed [31:0] o, logic signed [31:0] d,
                                      logic signed [31:0] c, logic [30:0] h,
                                      output longint tn, output longint tf);
      longint lo, hi;
      lo = longint'(c) - longint'(h);
      hi = longint'(c) + longint'(h);
      if (d == 0) begin
         tn = SMIN - 1;
         tf = SMAX + 1;
         return (longint'(o) >= lo) && (longint'(o) <= hi);
      end
      if (d > 0) begin
         tn = slab_quotient(lo - o, d);
         tf = slab_quotient(hi - o, d);
      end else begin
         tn = slab_quotient(hi - o, d);
         tf = slab_quotient(lo - o, d);
      end
      return 1'b1;
   endfunction

   function automatic rbs_pkg::rsp_type predict_entry(rbs_pkg::req_type r);
      rbs_pkg::rsp_type res;
      longint  tmin, tmax, an, af;
      logic    ok;
      ok = axis_span(r.origin_x, r.dir_x, r.box_center_x, r.box_half_x, tmin, tmax);
      if (ok) begin
         ok = axis_span(r.origin_y, r.dir_y, r.box_center_y, r.box_half_y, an, af);
         if (ok && (tmin > af || an > tmax)) ok = 1'b0;
         if (ok) begin
            if (an > tmin) tmin = an;
            if (af < tmax) tmax = af;
         end
      end
      if (ok) begin
         ok = axis_span(r.origin_z, r.dir_z, r.box_center_z, r.box_half_z, an, af);
         if (ok && (tmin > af || an > tmax)) ok = 1'b0;
         if (ok && an > tmin) tmin = an;
      end
      res.hit = ok;
      if (!ok) res.entry_distance = 32'h7fffffff;
      else if (tmin < SMIN) res.entry_distance = 32'h80000000;
      else if (tmin > SMAX) res.entry_distance = 32'h7fffffff;
      else res.entry_distance = tmin[31:0];
      return res;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7fffffff - $urandom_range(0, 3);
         2: return 32'h80000000 + $urandom_range(0, 3);
         3: return 32'h0;
         default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      endcase
   endfunction

   // Mostly rays aimed at a nearby box, the rest noise
   function automatic rbs_pkg::req_type rand_ray();
      rbs_pkg::req_type r;
      logic [31:0] v[12];
      for (int i = 0; i < 12; i++) v[i] = rand_coord();
      r = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
           v[9][30:0], v[10][30:0], v[11][30:0]};
      if ($urandom_range(0, 3) != 0) begin
         r.origin_x = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
         r.origin_y = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
         r.origin_z = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
         r.box_center_x = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
         r.box_center_y = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
         r.box_center_z = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
         r.box_half_x = $urandom_range(0, 32'h003fffff);
         r.box_half_y = $urandom_range(0, 32'h003fffff);
         r.box_half_z = $urandom_range(0, 32'h003fffff);
         // aim roughly at the box center
         r.dir_x = (r.box_center_x - r.origin_x) >>> $urandom_range(0, 8);
         r.dir_y = (r.box_center_y - r.origin_y) >>> $urandom_range(0, 8);
         r.dir_z = (r.box_center_z - r.origin_z) >>> $urandom_range(0, 8);
         if ($urandom_range(0, 7) == 0) r.dir_y = '0;
      end
      return r;
   endfunction

   // Check each result word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (hit_queue.size() == 0) begin
            $error("result word with no prediction waiting");
            fail_count++;
         end else begin
            rbs_pkg::rsp_type exp_rsp;
            exp_rsp = hit_queue.pop_front();
            if (rsp_data.hit !== exp_rsp.hit) begin
               $error("hit: expected %0d, actual %0d", exp_rsp.hit, rsp_data.hit);
               fail_count++;
            end
            if (rsp_data.entry_distance !== exp_rsp.entry_distance) begin
               $error("entry_distance: expected %0d, actual %0d",
                      exp_rsp.entry_distance, rsp_data.entry_distance);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted ray and no result word
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_ray(rbs_pkg::req_type r, logic known, rbs_pkg::rsp_type want,
                           int gap);
      rbs_pkg::rsp_type pred;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = predict_entry(r);
      if (known && pred !== want) begin
         $error("table row disagrees with predictor: expected %0d/%0d, predicted %0d/%0d",
                want.hit, want.entry_distance, pred.hit, pred.entry_distance);
         fail_count++;
      end
      hit_queue.push_back(known ? want : pred);
   endtask

   function automatic rbs_pkg::req_type mk(logic [31:0] ox, oy, oz, dx, dy, dz,
                                           cx, cy, cz, logic [30:0] hx, hy, hz);
      return {ox, oy, oz, dx, dy, dz, cx, cy, cz, hx, hy, hz};
   endfunction

   initial begin
      row_type table_rows[$];
      row_type row;
      int      gap;
      localparam logic [31:0] ONE = 32'h00010000;
      localparam rbs_pkg::rsp_type MISS = '{1'b0, 32'h7fffffff};

      // straight hit along x: box at 10, half 1 -> entry 9
      row = '{mk(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, ONE, ONE, ONE), 1'b1,
              '{1'b1, 9 * ONE}};
      table_rows.push_back(row);
      // zero direction, origin outside slab -> miss
      row = '{mk(0, 5 * ONE, 0, ONE, 0, 0, 10 * ONE, 0, 0, ONE, ONE, ONE), 1'b1, MISS};
      table_rows.push_back(row);
      // all parallel and inside -> most negative entry
      row = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE), 1'b1, '{1'b1, 32'h80000000}};
      table_rows.push_back(row);
      // parallel on boundary, inclusive
      row = '{mk(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE), 1'b1,
              '{1'b1, 32'h80000000}};
      table_rows.push_back(row);
      // box behind the ray -> still a hit, entry -11
      row = '{mk(0, 0, 0, ONE, 0, 0, -10 * ONE, 0, 0, ONE, ONE, ONE), 1'b1,
              '{1'b1, 32'hfff50000}};
      table_rows.push_back(row);
      // origin inside: negative entry -1
      row = '{mk(0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE), 1'b1,
              '{1'b1, -32'sh00010000}};
      table_rows.push_back(row);
      // negative direction
      row = '{mk(0, 0, 0, -ONE, 0, 0, -10 * ONE, 0, 0, ONE, ONE, ONE), 1'b1,
              '{1'b1, 9 * ONE}};
      table_rows.push_back(row);
      // extremes: saturating quotients
      table_rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            31'h7fffffff, 31'h7fffffff, 31'h7fffffff), 1'b0, MISS});
      table_rows.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000,
                            31'h7fffffff, 31'h7fffffff, 31'h7fffffff), 1'b0, MISS});
      table_rows.push_back('{mk(32'hffffffff, 32'hffffffff, 32'hffffffff,
                            32'hffffffff, 32'h7fffffff, 32'h1, 0, 0, 0,
                            0, 0, 0), 1'b0, MISS});
      table_rows.push_back('{mk(0, 0, 0, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                            32'h7fffffff, 32'h80000000, 0,
                            31'h7fffffff, 31'h0, 31'h7fffffff), 1'b0, MISS});
      // oblique ray, non-integer quotient
      table_rows.push_back('{mk(0, 0, 0, 3 * ONE, 7 * ONE, 32'h00005555,
                            5 * ONE, 11 * ONE, 0, ONE, 2 * ONE, 3 * ONE), 1'b0, MISS});
      // zero half size box, ray through it exactly
      table_rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, 4 * ONE, 4 * ONE, 4 * ONE,
                            0, 0, 0), 1'b0, MISS});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i])
         send_ray(table_rows[i].ray, table_rows[i].known, table_rows[i].want,
                  $urandom_range(0, 2));

      for (int n = 0; n < N_RANDOM; n++) begin
         // pause until the back end has drained once, midway
         if (n == N_RANDOM / 2) begin
            start <= 1'b0;
            while (hit_queue.size() != 0) @(posedge clock);
         end
         // alternate bursts without gaps and stretches with random gaps
         gap = ((n / 100) % 2) ? $urandom_range(0, 15) : 0;
         send_ray(rand_ray(), 1'b0, MISS, gap);
      end
      start <= 1'b0;

      while (hit_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

// File: files.f
rtl/rbs_pkg.sv
rtl/rbs_front.sv
rtl/rbs_queue.sv
rtl/rbs_div.sv
rtl/rbs_back.sv
rtl/ray_box_slab_test.sv
tb/testbench.sv
